// ----- sv/acpt_pkg.sv -----
// Package for the ARP cache probe table: sizes, opcodes, FSM states and
// the slot entry layout. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acpt_pkg;

   // Table geometry
   localparam int NUM_SLOTS = 256;
   localparam int SLOT_W = 8;
   localparam int PROBE_WINDOW_DEF = 10;

   // Field widths
   localparam int OP_W = 2;
   localparam int IP_W = 32;
   localparam int MAC_W = 48;
   localparam int STAMP_W = 32;
   localparam int REQ_DATA_W = 120;
   localparam int RSP_DATA_W = 64;

   // Opcodes
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_PUT = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_UPDATE
   } state_type;

   // One slot of the table memory
   typedef struct packed {
      logic [IP_W-1:0] ip;
      logic [MAC_W-1:0] mac;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

endpackage

`default_nettype wire

// ----- sv/arp_cache_probe_table.sv -----
// ARP cache probe table top level: 256-slot IPv4-to-MAC cache with
// linear probing in one slot memory. Depends on acpt_pkg.
//
//   channel | dir | handshake           | tdata fields (low bit up)
//   req     | in  | req_tvalid/tready   | opcode, ip_addr, mac_in, now_seconds
//   rsp     | out | rsp_tvalid/tready   | hit, mac_out, evicted, slot_index
//
// A request is accepted in the idle state. The probe state then issues one slot
// read per cycle and checks each slot once its read data is registered, and the
// update state commits the result; an empty or matching slot ends the probe
// early. A new request is taken only in the idle state; the slot memory has one read port.
// Reset clears the 256 valid bits at once; there is no clearing pass.
// The result register holds a stalled response; a new request is taken
// meanwhile and its result waits in the update state.
`timescale 1ns / 1ps
`default_nettype none

module arp_cache_probe_table
   import acpt_pkg::*;
#(
   parameter int PROBE_WINDOW = PROBE_WINDOW_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // opcode[1:0], ip_addr[33:2], mac_in[81:34], now_seconds[113:82], zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // hit[0], mac_out[48:1], evicted[49], slot_index[57:50], zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int CNT_W = $clog2(PROBE_WINDOW + 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(PROBE_WINDOW);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROBE_WINDOW - 1);

   state_type state_ff, state_in;

   // Captured request
   logic [OP_W-1:0]    op_ff;
   logic [IP_W-1:0]    ip_ff;
   logic [MAC_W-1:0]   mac_ff;
   logic [STAMP_W-1:0] now_ff;
   logic [SLOT_W-1:0]  base_ff;

   // Probe pipeline
   logic [CNT_W-1:0]   rd_cnt_ff, chk_cnt_ff;
   logic               rd_pend_ff, rd_valid_ff;
   logic [SLOT_W-1:0]  rd_slot_ff, rd_addr;
   entry_type          mem_q;

   // Probe outcome
   logic               found_ff, full_ff;
   logic [SLOT_W-1:0]  pos_ff, old_slot_ff, wr_slot;
   logic [STAMP_W-1:0] old_time_ff;
   logic [MAC_W-1:0]   hit_mac_ff;

   // Storage
   logic [NUM_SLOTS-1:0] valid_ff;
   entry_type            mem [NUM_SLOTS];

   // Response register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data;

   logic accept, issue, commit, mem_we;
   logic chk_empty, chk_match, chk_last, probe_end;
   logic [SLOT_W:0] home_sum;

   assign accept = req_tvalid & req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign home_sum = {1'b0, req_tdata[9:2]} + {1'b0, req_tdata[17:10]};
   assign rd_addr = base_ff + SLOT_W'(rd_cnt_ff);
   assign issue = (state_ff == ST_PROBE) && (rd_cnt_ff != CNT_END);

   // Check of the slot read in the previous cycle
   assign chk_empty = rd_pend_ff & ~rd_valid_ff;
   assign chk_match = rd_pend_ff & rd_valid_ff & (mem_q.ip == ip_ff);
   assign chk_last = rd_pend_ff & (chk_cnt_ff == CNT_LAST);
   assign probe_end = chk_empty | chk_match | chk_last;

   assign wr_slot = full_ff ? old_slot_ff : pos_ff;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commit strobes
   always_comb begin
      state_in = state_ff;
      commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tdata[1:0] == OP_LOOKUP || req_tdata[1:0] == OP_PUT ||
                   req_tdata[1:0] == OP_DELETE) begin
                  state_in = ST_PROBE;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_PROBE: begin
            if (probe_end) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               commit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign mem_we = commit && (op_ff == OP_PUT);

   // Result fields per opcode
   always_comb begin
      rsp_data = '0;
      case (op_ff)
         OP_LOOKUP: begin
            if (found_ff) begin
               rsp_data[0] = 1'b1;
               rsp_data[48:1] = hit_mac_ff;
               rsp_data[57:50] = pos_ff;
            end
         end
         OP_PUT: begin
            rsp_data[0] = found_ff;
            rsp_data[49] = full_ff;
            rsp_data[57:50] = wr_slot;
         end
         OP_DELETE: begin
            if (found_ff) begin
               rsp_data[0] = 1'b1;
               rsp_data[57:50] = pos_ff;
            end
         end
         default: begin
            rsp_data = '0;
         end
      endcase
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_tdata[1:0];
         ip_ff <= req_tdata[33:2];
         mac_ff <= req_tdata[81:34];
         now_ff <= req_tdata[113:82];
         base_ff <= home_sum[SLOT_W-1:0];
      end
   end

   // Probe counters: one read issued per cycle, checked in the next cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff <= '0;
         chk_cnt_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else if (accept) begin
         rd_cnt_ff <= '0;
         chk_cnt_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= issue;
         if (issue) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end
         if (rd_pend_ff) begin
            chk_cnt_ff <= chk_cnt_ff + 1'b1;
         end
      end
   end

   // Slot number and valid bit travel with the read
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_slot_ff <= rd_addr;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // Probe outcome: match, first empty slot, or oldest of a full window
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         full_ff <= 1'b0;
      end else if (accept) begin
         found_ff <= 1'b0;
         full_ff <= 1'b0;
      end else if (state_ff == ST_PROBE && rd_pend_ff) begin
         if (chk_empty) begin
            pos_ff <= rd_slot_ff;
         end else if (chk_match) begin
            pos_ff <= rd_slot_ff;
            found_ff <= 1'b1;
            hit_mac_ff <= mem_q.mac;
         end else begin
            if (chk_cnt_ff == '0 || mem_q.stamp < old_time_ff) begin
               old_slot_ff <= rd_slot_ff;
               old_time_ff <= mem_q.stamp;
            end
            if (chk_last) begin
               full_ff <= 1'b1;
            end
         end
      end
   end

   // Slot memory: one read port, one write port
   always_ff @(posedge clock) begin
      mem_q <= mem[rd_addr];
      if (mem_we) begin
         mem[wr_slot] <= '{ip: ip_ff, mac: mac_ff, stamp: now_ff};
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (commit) begin
         if (op_ff == OP_PUT) begin
            valid_ff[wr_slot] <= 1'b1;
         end else if (op_ff == OP_DELETE && found_ff) begin
            valid_ff[pos_ff] <= 1'b0;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= rsp_data;
      end
   end

   // A new response only leaves the update state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside update");

   // Eviction never reports a hit
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[49] |-> !rsp_data_ff[0])
      else $error("evicted with hit set");

   // Checks never run ahead of issued reads
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PROBE && rd_pend_ff |-> chk_cnt_ff < rd_cnt_ff)
      else $error("probe check ahead of read");

   // A committed response is visible in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      commit |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("commit lost");

endmodule

`default_nettype wire

// ----- tb/sv/arp_cache_probe_table_test.sv -----
// Self-checking testbench for arp_cache_probe_table: drives lookup, put and
// delete requests over the req stream and checks every rsp against an
// in-bench model of the probed slot table. Depends on acpt_pkg and the RTL.
`timescale 1ns / 1ps

module arp_cache_probe_table_test;
   import acpt_pkg::*;

   localparam int WINDOW = PROBE_WINDOW_DEF;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_REQS = 830;

   // One request as the initial block queues it
   typedef struct {
      logic [OP_W-1:0] op;
      logic [IP_W-1:0] ip;
      logic [MAC_W-1:0] mac;
      logic [STAMP_W-1:0] now;
      bit drain_first;   // hold until every reply is in
   } cache_req_type;

   // One reply, fields as they come out of rsp_tdata
   typedef struct packed {
      logic hit;
      logic [MAC_W-1:0] mac;
      logic evicted;
      logic [SLOT_W-1:0] slot;
   } cache_reply_type;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_SPARSE,
      RDY_BLOCKS
   } ready_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Model copy of the table
   bit cache_valid [NUM_SLOTS];
   logic [IP_W-1:0] cache_ip [NUM_SLOTS];
   logic [MAC_W-1:0] cache_mac [NUM_SLOTS];
   logic [STAMP_W-1:0] cache_stamp [NUM_SLOTS];

   cache_req_type op_queue[$];
   cache_reply_type cache_replies[$];
   int errors_seen = 0;
   int reply_count = 0;

   arp_cache_probe_table #(
      .PROBE_WINDOW(WINDOW)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Probe the window from the home slot, apply the request to the model
   // table and return the reply it should produce.
   function automatic cache_reply_type probe_and_update(input logic [OP_W-1:0] op,
                                                        input logic [IP_W-1:0] ip,
                                                        input logic [MAC_W-1:0] mac,
                                                        input logic [STAMP_W-1:0] now);
      cache_reply_type reply;
      logic [SLOT_W-1:0] home;
      logic [SLOT_W-1:0] s;
      logic [SLOT_W-1:0] pos;
      logic [SLOT_W-1:0] oldest;
      bit found;
      bit empty_seen;
      bit stopped;
      int i;
      reply = '0;
      if (op == OP_UNUSED)
         return reply;
      home = ip[7:0] + ip[15:8];
      oldest = home;
      pos = '0;
      found = 0;
      empty_seen = 0;
      stopped = 0;
      for (i = 0; i < WINDOW; i++) begin
         if (!stopped) begin
            s = home + SLOT_W'(i);
            if (!cache_valid[s]) begin
               stopped = 1;
               empty_seen = 1;
               pos = s;
            end else if (cache_ip[s] == ip) begin
               stopped = 1;
               found = 1;
               pos = s;
            end else if (cache_stamp[s] < cache_stamp[oldest]) begin
               oldest = s;
            end
         end
      end
      case (op)
         OP_LOOKUP: begin
            if (found) begin
               reply.hit = 1'b1;
               reply.mac = cache_mac[pos];
               reply.slot = pos;
            end
         end
         OP_PUT: begin
            if (found) begin
               reply.hit = 1'b1;
            end else if (!empty_seen) begin
               // window full: replace the oldest, first in probe order on ties
               pos = oldest;
               reply.evicted = 1'b1;
            end
            cache_valid[pos] = 1;
            cache_ip[pos] = ip;
            cache_mac[pos] = mac;
            cache_stamp[pos] = now;
            reply.slot = pos;
         end
         OP_DELETE: begin
            if (found) begin
               cache_valid[pos] = 0;
               reply.hit = 1'b1;
               reply.slot = pos;
            end
         end
         default: ;
      endcase
      return reply;
   endfunction

   // Address whose two low octets sum to the given home slot
   function automatic logic [IP_W-1:0] ip_at_home(input logic [SLOT_W-1:0] home);
      logic [IP_W-1:0] ip;
      ip = $urandom;
      ip[7:0] = home - ip[15:8];
      return ip;
   endfunction

   function automatic cache_req_type make_req(input logic [OP_W-1:0] op,
                                              input logic [IP_W-1:0] ip,
                                              input logic [MAC_W-1:0] mac,
                                              input logic [STAMP_W-1:0] now);
      cache_req_type r;
      r.op = op;
      r.ip = ip;
      r.mac = mac;
      r.now = now;
      r.drain_first = 0;
      return r;
   endfunction

   // Request driver: bursts of random length, random gaps between them
   always @(posedge clock) begin : driver
      int burst_left;
      int gap_left;
      bit send;
      cache_req_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            cache_replies.push_back(probe_and_update(req_tdata[1:0], req_tdata[33:2],
                                                     req_tdata[81:34], req_tdata[113:82]));
         if (!req_tvalid || req_tready) begin
            send = 0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (op_queue.size() != 0 &&
                         !(op_queue[0].drain_first && cache_replies.size() != 0)) begin
               send = 1;
               r = op_queue.pop_front();
               req_tdata <= {6'b0, r.now, r.mac, r.ip, r.op};
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               end else begin
                  burst_left--;
               end
            end
            req_tvalid <= send;
         end
      end
   end

   // Reply monitor with its own stall pattern
   always @(posedge clock) begin : monitor
      ready_mode_type mode;
      int mode_left;
      int hold_left;
      bit hold_level;
      bit ready_next;
      cache_reply_type got;
      cache_reply_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         mode = RDY_ALWAYS;
         mode_left = 0;
         hold_left = 0;
         hold_level = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.hit = rsp_tdata[0];
            got.mac = rsp_tdata[48:1];
            got.evicted = rsp_tdata[49];
            got.slot = rsp_tdata[57:50];
            if (cache_replies.size() == 0) begin
               errors_seen++;
               $display("%0t: unexpected reply hit=%0b mac=%h evicted=%0b slot=%0d",
                        $time, got.hit, got.mac, got.evicted, got.slot);
            end else begin
               want = cache_replies.pop_front();
               if (got !== want) begin
                  errors_seen++;
                  $display({"%0t: reply %0d expected hit=%0b mac=%h evicted=%0b slot=%0d,",
                            " got hit=%0b mac=%h evicted=%0b slot=%0d"},
                           $time, reply_count, want.hit, want.mac, want.evicted,
                           want.slot, got.hit, got.mac, got.evicted, got.slot);
               end
            end
            reply_count++;
         end
         if (mode_left == 0) begin
            mode = ready_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 256);
         end else begin
            mode_left--;
         end
         case (mode)
            RDY_ALWAYS: ready_next = 1;
            RDY_COIN: ready_next = $urandom_range(0, 1);
            RDY_SPARSE: ready_next = ($urandom_range(0, 3) == 0);
            default: begin
               if (hold_left == 0) begin
                  hold_level = ~hold_level;
                  hold_left = $urandom_range(1, 20);
               end else begin
                  hold_left--;
               end
               ready_next = hold_level;
            end
         endcase
         rsp_tready <= ready_next;
      end
   end

   // Stimulus and end of run
   initial begin : stimulus
      logic [IP_W-1:0] cluster_ip [11];
      logic [STAMP_W-1:0] cluster_stamp [10];
      logic [IP_W-1:0] ip_pool[$];
      logic [SLOT_W-1:0] hot_homes [4];
      logic [STAMP_W-1:0] stamp_base;
      logic [OP_W-1:0] op;
      logic [IP_W-1:0] ip;
      logic [STAMP_W-1:0] now;
      cache_req_type r;
      int n;
      int roll;
      cluster_stamp = '{32'd9, 32'd4, 32'd7, 32'd2, 32'd8, 32'd2, 32'd6, 32'd5, 32'd3, 32'd9};
      hot_homes = '{8'hFB, 8'h40, 8'h45, 8'h80};
      for (n = 0; n < 11; n++)
         cluster_ip[n] = ip_at_home(8'hFC);

      // Directed: misses on an empty table, extremes, refresh, delete
      op_queue.push_back(make_req(OP_LOOKUP, '0, '0, '0));
      op_queue.push_back(make_req(OP_LOOKUP, '1, '1, '1));
      op_queue.push_back(make_req(OP_PUT, '1, '1, '1));
      op_queue.push_back(make_req(OP_LOOKUP, '1, '0, '0));
      op_queue.push_back(make_req(OP_PUT, '1, '0, '0));
      op_queue.push_back(make_req(OP_LOOKUP, '1, '1, '1));
      op_queue.push_back(make_req(OP_DELETE, '1, '0, '0));
      op_queue.push_back(make_req(OP_DELETE, '1, '0, '0));
      op_queue.push_back(make_req(OP_UNUSED, '1, '1, '1));
      // Fill a window that wraps past slot 255, with tied oldest stamps
      for (n = 0; n < 10; n++)
         op_queue.push_back(make_req(OP_PUT, cluster_ip[n], MAC_W'({$urandom, $urandom}),
                                     cluster_stamp[n]));
      // Full window, no match: eviction of the first oldest
      r = make_req(OP_PUT, cluster_ip[10], '1, 32'd100);
      r.drain_first = 1;
      op_queue.push_back(r);
      op_queue.push_back(make_req(OP_LOOKUP, cluster_ip[10], '0, '0));
      op_queue.push_back(make_req(OP_LOOKUP, cluster_ip[3], '0, '0));
      // A hole in the run ends the probe early
      op_queue.push_back(make_req(OP_DELETE, cluster_ip[1], '0, '0));
      op_queue.push_back(make_req(OP_LOOKUP, cluster_ip[5], '0, '0));
      op_queue.push_back(make_req(OP_PUT, ip_at_home(8'hFC), '0, 32'd50));

      // Random: puts, lookups and deletes crowded onto a few home slots
      stamp_base = $urandom_range(0, 1000);
      for (n = 0; n < RANDOM_REQS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 45)
            op = OP_PUT;
         else if (roll < 75)
            op = OP_LOOKUP;
         else if (roll < 97)
            op = OP_DELETE;
         else
            op = OP_UNUSED;
         if (ip_pool.size() != 0 && $urandom_range(0, 99) < ((op == OP_PUT) ? 35 : 70))
            ip = ip_pool[$urandom_range(0, ip_pool.size() - 1)];
         else if ($urandom_range(0, 4) != 0)
            ip = ip_at_home(hot_homes[$urandom_range(0, 3)] + SLOT_W'($urandom_range(0, 2)));
         else
            ip = $urandom;
         roll = $urandom_range(0, 9);
         if (roll < 5) begin
            stamp_base += $urandom_range(0, 3);
            now = stamp_base;
         end else if (roll < 8) begin
            now = $urandom_range(0, 7);
         end else begin
            now = $urandom;
         end
         if (op == OP_PUT) begin
            if (ip_pool.size() < 64)
               ip_pool.push_back(ip);
            else
               ip_pool[$urandom_range(0, 63)] = ip;
         end
         r = make_req(op, ip, MAC_W'({$urandom, $urandom}), now);
         r.drain_first = (n % 200 == 199);
         op_queue.push_back(r);
      end

      while (op_queue.size() != 0 || req_tvalid)
         @(posedge clock);
      while (cache_replies.size() != 0)
         @(posedge clock);
      repeat (4 * (WINDOW + 3)) @(posedge clock);
      if (errors_seen == 0 && cache_replies.size() == 0)
         $display("arp_cache_probe_table regression: pass");
      else
         $display("arp_cache_probe_table regression: fail");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("arp_cache_probe_table regression: fail");
      $finish;
   end

endmodule
